// File: design/ole_pkg.sv
package ole_pkg;

    // Store geometry
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 4;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT  = 4'd0,
        OP_INS_END    = 4'd1,
        OP_INS_BEFORE = 4'd2,
        OP_INS_AFTER  = 4'd3,
        OP_DEL_FIRST  = 4'd4,
        OP_DEL_LAST   = 4'd5,
        OP_DEL_KEY    = 4'd6,
        OP_CLEAR      = 4'd7,
        OP_SORT       = 4'd8,
        OP_DUMP       = 4'd9
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOKEY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FND_RD,
        S_FND_CHK,
        S_SHR_RD,
        S_SHR_WR,
        S_PUT,
        S_SHL_RD,
        S_SHL_WR,
        S_SRT_A,
        S_SRT_AL,
        S_SRT_B,
        S_SRT_C,
        S_SRT_WI,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_DONE
    } t_state;

    // Request from the sequencer to the element RAM
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

// File: design/ole_if.sv
// Command channel: one list operation per item
interface ole_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ole_pkg::OP_W-1:0]            opcode;
    logic signed [ole_pkg::DATA_W-1:0]   new_value;
    logic signed [ole_pkg::DATA_W-1:0]   match_key;

    modport source (output valid, opcode, new_value, match_key, input ready);
    modport sink   (input valid, opcode, new_value, match_key, output ready);
endinterface

// Result channel: status or dumped element per item
interface ole_res_if;
    logic                                valid;
    logic                                ready;
    logic [ole_pkg::ST_W-1:0]            status;
    logic signed [ole_pkg::DATA_W-1:0]   item_value;
    logic [ole_pkg::LEN_W-1:0]           list_length;
    logic                                last_of_run;

    modport source (output valid, status, item_value, list_length, last_of_run, input ready);
    modport sink   (input valid, status, item_value, list_length, last_of_run, output ready);
endinterface

// File: design/ole_ram.sv
module ole_ram (
    input  logic                          i_clk,
    input  ole_pkg::t_ram_req             i_req,
    output logic [ole_pkg::DATA_W-1:0]    o_rdata
);

    logic [ole_pkg::DATA_W-1:0] mem [ole_pkg::DEPTH];
    logic [ole_pkg::DATA_W-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ole_ctrl.sv
module ole_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ole_cmd_if.sink                       i_cmd,
    ole_res_if.source                     o_res,
    output ole_pkg::t_ram_req             o_ram_req,
    input  logic [ole_pkg::DATA_W-1:0]    i_ram_rdata
);

    localparam int CNT_W = ole_pkg::CNT_W;
    localparam int IDX_W = ole_pkg::IDX_W;
    localparam int DW    = ole_pkg::DATA_W;

    ole_pkg::t_state     r_state,  n_state;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [CNT_W-1:0]    r_idx,    n_idx;
    logic [CNT_W-1:0]    r_j,      n_j;
    logic [CNT_W-1:0]    r_pos,    n_pos;
    logic [ole_pkg::OP_W-1:0] r_op, n_op;
    logic [DW-1:0]       r_val,    n_val;
    logic [DW-1:0]       r_a,      n_a;
    ole_pkg::t_status    r_status, n_status;

    // Output register
    logic                r_ovalid;
    ole_pkg::t_status    r_o_status;
    logic [DW-1:0]       r_o_item;
    logic [CNT_W-1:0]    r_o_len;
    logic                r_o_last;

    logic                out_load;
    logic                load_ok;
    ole_pkg::t_status    out_status;
    logic [DW-1:0]       out_item;
    logic                out_last;

    logic [CNT_W-1:0]    idx_inc, idx_dec, j_inc, cnt_dec;
    logic                cmp_eq, cmp_lt;
    ole_pkg::t_ram_req   ram_req;

    assign idx_inc = r_idx + CNT_W'(1);
    assign idx_dec = r_idx - CNT_W'(1);
    assign j_inc   = r_j + CNT_W'(1);
    assign cnt_dec = r_count - CNT_W'(1);

    // Shared compare unit: read data against the held operand
    assign cmp_eq = (i_ram_rdata == r_a);
    assign cmp_lt = ($signed(i_ram_rdata) < $signed(r_a));

    assign load_ok = !r_ovalid || o_res.ready;

    // Sequencer: next state, RAM requests and result loads
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_j        = r_j;
        n_pos      = r_pos;
        n_op       = r_op;
        n_val      = r_val;
        n_a        = r_a;
        n_status   = r_status;
        ram_req       = '0;
        ram_req.raddr = r_idx[IDX_W-1:0];
        out_load   = 1'b0;
        out_status = r_status;
        out_item   = '0;
        out_last   = 1'b1;

        case (r_state)
            ole_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_status = ole_pkg::ST_OK;
                    n_op     = i_cmd.opcode;
                    n_val    = i_cmd.new_value;
                    n_a      = i_cmd.match_key;
                    n_idx    = '0;
                    n_state  = ole_pkg::S_DONE;
                    case (i_cmd.opcode)
                        ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_END: begin
                            if (r_count >= CNT_W'(ole_pkg::DEPTH)) begin
                                n_status = ole_pkg::ST_FULL;
                            end else begin
                                n_pos = (i_cmd.opcode == ole_pkg::OP_INS_FRONT) ? '0 : r_count;
                                n_idx = r_count;
                                n_state = (i_cmd.opcode == ole_pkg::OP_INS_FRONT &&
                                           r_count != '0) ? ole_pkg::S_SHR_RD : ole_pkg::S_PUT;
                            end
                        end
                        ole_pkg::OP_INS_BEFORE, ole_pkg::OP_INS_AFTER: begin
                            if (r_count >= CNT_W'(ole_pkg::DEPTH)) begin
                                n_status = ole_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_status = ole_pkg::ST_EMPTY;
                            end else begin
                                n_state = ole_pkg::S_FND_RD;
                            end
                        end
                        ole_pkg::OP_DEL_KEY: begin
                            if (r_count == '0) begin
                                n_status = ole_pkg::ST_EMPTY;
                            end else begin
                                n_state = ole_pkg::S_FND_RD;
                            end
                        end
                        ole_pkg::OP_DEL_FIRST, ole_pkg::OP_DEL_LAST: begin
                            if (r_count == '0) begin
                                n_status = ole_pkg::ST_EMPTY;
                            end else begin
                                n_count = cnt_dec;
                                n_idx   = (i_cmd.opcode == ole_pkg::OP_DEL_FIRST) ? '0 : cnt_dec;
                                if (i_cmd.opcode == ole_pkg::OP_DEL_FIRST &&
                                    cnt_dec != '0) begin
                                    n_state = ole_pkg::S_SHL_RD;
                                end
                            end
                        end
                        ole_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        ole_pkg::OP_SORT: begin
                            if (r_count != '0) begin
                                n_state = ole_pkg::S_SRT_A;
                            end
                        end
                        ole_pkg::OP_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ole_pkg::ST_EMPTY;
                            end else begin
                                n_state = ole_pkg::S_DUMP_RD;
                            end
                        end
                        default: begin
                            n_status = ole_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // Walk the list looking for the key
            ole_pkg::S_FND_RD: begin
                n_state = ole_pkg::S_FND_CHK;
            end
            ole_pkg::S_FND_CHK: begin
                if (cmp_eq) begin
                    case (r_op)
                        ole_pkg::OP_INS_BEFORE: begin
                            n_pos   = r_idx;
                            n_idx   = r_count;
                            n_state = ole_pkg::S_SHR_RD;
                        end
                        ole_pkg::OP_INS_AFTER: begin
                            n_pos   = idx_inc;
                            n_idx   = r_count;
                            n_state = (idx_inc != r_count) ? ole_pkg::S_SHR_RD
                                                           : ole_pkg::S_PUT;
                        end
                        default: begin
                            n_count = cnt_dec;
                            n_state = (r_idx < cnt_dec) ? ole_pkg::S_SHL_RD
                                                        : ole_pkg::S_DONE;
                        end
                    endcase
                end else if (idx_inc == r_count) begin
                    n_status = ole_pkg::ST_NOKEY;
                    n_state  = ole_pkg::S_DONE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = ole_pkg::S_FND_RD;
                end
            end

            // Move entries up by one to open a slot at r_pos
            ole_pkg::S_SHR_RD: begin
                ram_req.raddr = idx_dec[IDX_W-1:0];
                n_state = ole_pkg::S_SHR_WR;
            end
            ole_pkg::S_SHR_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx[IDX_W-1:0];
                ram_req.wdata = i_ram_rdata;
                n_idx   = idx_dec;
                n_state = (idx_dec != r_pos) ? ole_pkg::S_SHR_RD : ole_pkg::S_PUT;
            end
            ole_pkg::S_PUT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_pos[IDX_W-1:0];
                ram_req.wdata = r_val;
                n_count = r_count + CNT_W'(1);
                n_state = ole_pkg::S_DONE;
            end

            // Move entries down by one to close the slot at r_idx
            ole_pkg::S_SHL_RD: begin
                ram_req.raddr = idx_inc[IDX_W-1:0];
                n_state = ole_pkg::S_SHL_WR;
            end
            ole_pkg::S_SHL_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx[IDX_W-1:0];
                ram_req.wdata = i_ram_rdata;
                n_idx   = idx_inc;
                n_state = (idx_inc < r_count) ? ole_pkg::S_SHL_RD : ole_pkg::S_DONE;
            end

            // Exchange sort: hold entry i in r_a, sweep j over the rest
            ole_pkg::S_SRT_A: begin
                n_state = ole_pkg::S_SRT_AL;
            end
            ole_pkg::S_SRT_AL: begin
                n_a     = i_ram_rdata;
                n_j     = idx_inc;
                n_state = (idx_inc < r_count) ? ole_pkg::S_SRT_B : ole_pkg::S_DONE;
            end
            ole_pkg::S_SRT_B: begin
                ram_req.raddr = r_j[IDX_W-1:0];
                n_state = ole_pkg::S_SRT_C;
            end
            ole_pkg::S_SRT_C: begin
                if (cmp_lt) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_j[IDX_W-1:0];
                    ram_req.wdata = r_a;
                    n_a = i_ram_rdata;
                end
                n_j     = j_inc;
                n_state = (j_inc < r_count) ? ole_pkg::S_SRT_B : ole_pkg::S_SRT_WI;
            end
            ole_pkg::S_SRT_WI: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_idx[IDX_W-1:0];
                ram_req.wdata = r_a;
                n_idx   = idx_inc;
                n_state = ole_pkg::S_SRT_A;
            end

            // Emit one item per element, front to back
            ole_pkg::S_DUMP_RD: begin
                n_state = ole_pkg::S_DUMP_OUT;
            end
            ole_pkg::S_DUMP_OUT: begin
                if (load_ok) begin
                    out_load   = 1'b1;
                    out_status = ole_pkg::ST_OK;
                    out_item   = i_ram_rdata;
                    out_last   = (idx_inc == r_count);
                    n_idx      = idx_inc;
                    n_state    = (idx_inc == r_count) ? ole_pkg::S_IDLE
                                                      : ole_pkg::S_DUMP_RD;
                end
            end

            // Emit the status item
            ole_pkg::S_DONE: begin
                if (load_ok) begin
                    out_load = 1'b1;
                    n_state  = ole_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_op     <= n_op;
        r_val    <= n_val;
        r_a      <= n_a;
        r_status <= n_status;
    end

    // Output register: load a new item, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= out_status;
            r_o_item   <= out_item;
            r_o_len    <= n_count;
            r_o_last   <= out_last;
        end
    end

    assign i_cmd.ready       = (r_state == ole_pkg::S_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.status      = r_o_status;
    assign o_res.item_value  = r_o_item;
    assign o_res.list_length = ole_pkg::LEN_W'(r_o_len);
    assign o_res.last_of_run = r_o_last;
    assign o_ram_req         = ram_req;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ole_pkg::DEPTH))
        else $error("element count above depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && i_cmd.opcode == ole_pkg::OP_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the list");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_IDLE) |-> !ram_req.we)
        else $error("RAM write while idle");

    a_sort_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_SRT_B || r_state == ole_pkg::S_SRT_C) |=> $stable(r_count))
        else $error("length changed during sort");

endmodule

// File: design/ordered_list_engine.sv
// Ordered list engine: holds up to DEPTH (32) signed 32-bit elements in an
// element RAM with one write port and one registered read port, plus a
// length count. Each command item is worked by a small sequencer around one
// shared comparator, and the command side is not ready until the item's
// results are loaded. For a list of n elements: plain status operations go
// straight to the status item; a key search reads and checks each element
// visited; each element moved by an insert or delete costs one RAM read and
// one write, plus one write to place a new value; a dump reads and emits
// each element in turn; the exchange sort does one compare per RAM read.
// Results sit in an output register, so the engine moves on while the last
// item waits to be taken. Element RAM contents are undefined after reset;
// only data read from positions below the length is ever used.
module ordered_list_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ole_cmd_if.sink      i_cmd,
    ole_res_if.source    o_res
);

    ole_pkg::t_ram_req              ram_req;
    logic [ole_pkg::DATA_W-1:0]     ram_rdata;

    // Sequencer and compare unit
    ole_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    // Element store
    ole_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

// File: test/ordered_list_engine_tb.sv
module ordered_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes outside the defined set; the engine answers them with a plain status
    localparam logic [ole_pkg::OP_W-1:0] OP_SPARE_LO = 4'd10;
    localparam logic [ole_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

    localparam int RANDOM_ITEMS = 200;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        ole_pkg::t_status                  status;
        logic signed [ole_pkg::DATA_W-1:0] item_value;
        logic [ole_pkg::LEN_W-1:0]         list_length;
        logic                              last_of_run;
    } t_list_result;

    // Shadow copy of the list plus the results each command should produce
    class t_list_checker;
        logic signed [ole_pkg::DATA_W-1:0] shadow_list[$];
        t_list_result                      pending_results[$];
        int errors;
        int commands;
        int results_seen;
        int full_hits;
        int empty_hits;
        int miss_hits;
        int dumps;
        int sorts;

        task report(string what);
            $display("ERROR: t=%0t %s", $time, what);
            errors++;
        endtask

        function int find_first(logic signed [ole_pkg::DATA_W-1:0] key);
            foreach (shadow_list[i])
                if (shadow_list[i] == key) return i;
            return -1;
        endfunction

        function void push_status(ole_pkg::t_status st);
            t_list_result r;
            r.status      = st;
            r.item_value  = '0;
            r.list_length = ole_pkg::LEN_W'(shadow_list.size());
            r.last_of_run = 1'b1;
            pending_results.push_back(r);
            case (st)
                ole_pkg::ST_FULL:  full_hits++;
                ole_pkg::ST_EMPTY: empty_hits++;
                ole_pkg::ST_NOKEY: miss_hits++;
                default: ;
            endcase
        endfunction

        // Ascending exchange sort on signed values
        function void sort_shadow();
            logic signed [ole_pkg::DATA_W-1:0] t;
            for (int i = 0; i < shadow_list.size(); i++)
                for (int j = i + 1; j < shadow_list.size(); j++)
                    if (shadow_list[j] < shadow_list[i]) begin
                        t = shadow_list[i];
                        shadow_list[i] = shadow_list[j];
                        shadow_list[j] = t;
                    end
        endfunction

        // Apply one accepted command and queue the results it causes
        function void note_command(logic [ole_pkg::OP_W-1:0] op,
                                   logic signed [ole_pkg::DATA_W-1:0] val,
                                   logic signed [ole_pkg::DATA_W-1:0] key);
            int n;
            int pos;
            t_list_result r;
            n = shadow_list.size();
            commands++;
            case (op)
                ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_END: begin
                    if (n >= ole_pkg::DEPTH) begin
                        push_status(ole_pkg::ST_FULL);
                    end else begin
                        if (op == ole_pkg::OP_INS_FRONT) shadow_list.push_front(val);
                        else shadow_list.push_back(val);
                        push_status(ole_pkg::ST_OK);
                    end
                end
                ole_pkg::OP_INS_BEFORE, ole_pkg::OP_INS_AFTER: begin
                    if (n >= ole_pkg::DEPTH) begin
                        push_status(ole_pkg::ST_FULL);
                    end else if (n == 0) begin
                        push_status(ole_pkg::ST_EMPTY);
                    end else begin
                        pos = find_first(key);
                        if (pos < 0) begin
                            push_status(ole_pkg::ST_NOKEY);
                        end else begin
                            shadow_list.insert(op == ole_pkg::OP_INS_BEFORE ? pos : pos + 1,
                                               val);
                            push_status(ole_pkg::ST_OK);
                        end
                    end
                end
                ole_pkg::OP_DEL_FIRST, ole_pkg::OP_DEL_LAST: begin
                    if (n == 0) begin
                        push_status(ole_pkg::ST_EMPTY);
                    end else begin
                        if (op == ole_pkg::OP_DEL_FIRST) void'(shadow_list.pop_front());
                        else void'(shadow_list.pop_back());
                        push_status(ole_pkg::ST_OK);
                    end
                end
                ole_pkg::OP_DEL_KEY: begin
                    if (n == 0) begin
                        push_status(ole_pkg::ST_EMPTY);
                    end else begin
                        pos = find_first(key);
                        if (pos < 0) begin
                            push_status(ole_pkg::ST_NOKEY);
                        end else begin
                            shadow_list.delete(pos);
                            push_status(ole_pkg::ST_OK);
                        end
                    end
                end
                ole_pkg::OP_CLEAR: begin
                    shadow_list.delete();
                    push_status(ole_pkg::ST_OK);
                end
                ole_pkg::OP_SORT: begin
                    sorts++;
                    sort_shadow();
                    push_status(ole_pkg::ST_OK);
                end
                ole_pkg::OP_DUMP: begin
                    dumps++;
                    if (n == 0) begin
                        push_status(ole_pkg::ST_EMPTY);
                    end else begin
                        foreach (shadow_list[i]) begin
                            r.status      = ole_pkg::ST_OK;
                            r.item_value  = shadow_list[i];
                            r.list_length = ole_pkg::LEN_W'(n);
                            r.last_of_run = (i == n - 1);
                            pending_results.push_back(r);
                        end
                    end
                end
                default: push_status(ole_pkg::ST_OK);
            endcase
        endfunction

        // Compare one accepted result with the oldest pending one
        task check_result(logic [ole_pkg::ST_W-1:0] st,
                          logic signed [ole_pkg::DATA_W-1:0] val,
                          logic [ole_pkg::LEN_W-1:0] len, logic last);
            t_list_result r;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result st=%0d val=%0d len=%0d last=%0b",
                                 st, val, len, last));
                return;
            end
            r = pending_results.pop_front();
            if (st !== r.status)
                report($sformatf("status got %0d want %0d", st, r.status));
            if (val !== r.item_value)
                report($sformatf("item_value got %0d want %0d", val, r.item_value));
            if (len !== r.list_length)
                report($sformatf("list_length got %0d want %0d", len, r.list_length));
            if (last !== r.last_of_run)
                report($sformatf("last_of_run got %0b want %0b", last, r.last_of_run));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ole_cmd_if cmd_if();
    ole_res_if res_if();

    ordered_list_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    t_list_checker sb;
    bit cmd_burst;
    bit res_burst;
    int idle_cycles = 0;

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // Present one command item and hold it until the engine takes it
    task send_cmd(logic [ole_pkg::OP_W-1:0] op, logic signed [ole_pkg::DATA_W-1:0] val,
                  logic signed [ole_pkg::DATA_W-1:0] key);
        int gap;
        if ($urandom_range(0, 31) == 0) cmd_burst = !cmd_burst;
        gap = cmd_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.opcode    <= op;
        cmd_if.new_value <= val;
        cmd_if.match_key <= key;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(op, val, key);
    endtask

    // Drop valid and hold until every pending result has come back
    task hold_until_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    // Mix of extremes, small repeating values and full-range values
    function logic signed [ole_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // Mostly a key that is present, sometimes one that likely is not
    function logic signed [ole_pkg::DATA_W-1:0] pick_key();
        if (sb.shadow_list.size() > 0 && $urandom_range(0, 3) != 0)
            return sb.shadow_list[$urandom_range(0, sb.shadow_list.size() - 1)];
        return rand_value();
    endfunction

    function logic [ole_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return ole_pkg::OP_INS_FRONT;
        if (r < 30) return ole_pkg::OP_INS_END;
        if (r < 40) return ole_pkg::OP_INS_BEFORE;
        if (r < 50) return ole_pkg::OP_INS_AFTER;
        if (r < 60) return ole_pkg::OP_DEL_FIRST;
        if (r < 68) return ole_pkg::OP_DEL_LAST;
        if (r < 80) return ole_pkg::OP_DEL_KEY;
        if (r < 82) return ole_pkg::OP_CLEAR;
        if (r < 86) return ole_pkg::OP_SORT;
        if (r < 95) return ole_pkg::OP_DUMP;
        return ole_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    // Result side: random back-pressure, check each accepted item
    initial begin
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int stall;
            if ($urandom_range(0, 31) == 0) res_burst = !res_burst;
            stall = res_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            sb.check_result(res_if.status, res_if.item_value, res_if.list_length,
                            res_if.last_of_run);
        end
    end

    // Command side: reset, directed cases, random episodes, drain
    initial begin
        int target;
        sb = new();
        i_rst_n          <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.opcode    <= ole_pkg::OP_DUMP;
        cmd_if.new_value <= '0;
        cmd_if.match_key <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: every operation that can flag it, plus clear and sort
        send_cmd(ole_pkg::OP_DUMP, 0, 0);
        send_cmd(ole_pkg::OP_DEL_FIRST, 0, 0);
        send_cmd(ole_pkg::OP_DEL_LAST, 0, 0);
        send_cmd(ole_pkg::OP_DEL_KEY, 0, 0);
        send_cmd(ole_pkg::OP_INS_BEFORE, 1, 0);
        send_cmd(ole_pkg::OP_INS_AFTER, 1, 0);
        send_cmd(ole_pkg::OP_SORT, 0, 0);
        send_cmd(ole_pkg::OP_CLEAR, 0, 0);
        // Extremes at both ends, then key matches at head and tail
        send_cmd(ole_pkg::OP_INS_FRONT, 32'sh7fffffff, 0);
        send_cmd(ole_pkg::OP_INS_END, 32'sh80000000, 0);
        send_cmd(ole_pkg::OP_INS_FRONT, 0, 32'sh7fffffff);
        send_cmd(ole_pkg::OP_INS_BEFORE, -1, 0);
        send_cmd(ole_pkg::OP_INS_AFTER, 5, 32'sh80000000);
        // Keys not present
        send_cmd(ole_pkg::OP_INS_BEFORE, 7, 12345);
        send_cmd(ole_pkg::OP_INS_AFTER, 7, -12345);
        send_cmd(ole_pkg::OP_DEL_KEY, 0, 999);
        // Duplicate value: delete must take the first one
        send_cmd(ole_pkg::OP_INS_END, 0, 0);
        send_cmd(ole_pkg::OP_DEL_KEY, 0, 0);
        send_cmd(ole_pkg::OP_DUMP, 0, 0);
        send_cmd(ole_pkg::OP_SORT, 0, 0);
        send_cmd(ole_pkg::OP_DUMP, 0, 0);
        send_cmd(ole_pkg::OP_DEL_KEY, 0, 32'sh80000000);
        send_cmd(ole_pkg::OP_DEL_FIRST, 0, 0);
        send_cmd(ole_pkg::OP_DEL_LAST, 0, 0);
        send_cmd(OP_SPARE_LO, 32'shffffffff, 32'shffffffff);
        send_cmd(OP_SPARE_HI, 0, 0);
        hold_until_drained();

        // Random episodes: fill to full, short mixes, occasional clear
        target = sb.commands + RANDOM_ITEMS;
        while (sb.commands < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    while (sb.shadow_list.size() < ole_pkg::DEPTH)
                        send_cmd(ole_pkg::OP_W'($urandom_range(ole_pkg::OP_INS_FRONT,
                                                               ole_pkg::OP_INS_AFTER)),
                                 rand_value(), pick_key());
                    repeat (2)
                        send_cmd(ole_pkg::OP_W'($urandom_range(ole_pkg::OP_INS_FRONT,
                                                               ole_pkg::OP_INS_AFTER)),
                                 rand_value(), pick_key());
                    send_cmd(ole_pkg::OP_DUMP, rand_value(), rand_value());
                    if ($urandom_range(0, 1)) send_cmd(ole_pkg::OP_SORT, 0, 0);
                end
                1: send_cmd(ole_pkg::OP_CLEAR, rand_value(), rand_value());
                default: begin
                    repeat (8) send_cmd(pick_op(), rand_value(), pick_key());
                end
            endcase
            if ($urandom_range(0, 15) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

        $display("Ran %0d commands, checked %0d results, %0d dumps, %0d sorts",
                 sb.commands, sb.results_seen, sb.dumps, sb.sorts);
        $display("Flags raised: store full %0d, list empty %0d, key not found %0d",
                 sb.full_hits, sb.empty_hits, sb.miss_hits);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
